/* rtl/ssu_pkg.sv */
// Shared types, widths and constants of the sinh series unit.
// No dependencies; used by ssu_mult, ssu_core and sinh_series_unit.
`default_nettype none

package ssu_pkg;

  localparam int MAX_TERMS  = 16;
  localparam int FRAC_BITS  = 12;
  localparam int GUARD_BITS = 16;
  localparam int RECIP_BITS = 32;

  localparam int X_W     = 16;
  localparam int OUT_W   = 24;
  localparam int CFG_W   = 5;
  localparam int MAG_W   = 16;
  localparam int X2_W    = 31;
  localparam int TERM_W  = 40;
  localparam int SUM_W   = 40;
  localparam int MID_W   = 44;
  localparam int RECIP_W = 30;
  localparam int K_W     = 4;

  localparam int TERM_HALF = TERM_W / 2;
  localparam int MID_HALF  = MID_W / 2;

  localparam int MUL_A_W = 22;
  localparam int MUL_B_W = 31;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = MUL_P_W + MID_HALF;

  localparam int RES_W = SUM_W + 1 - GUARD_BITS;

  localparam logic [CFG_W-1:0] TERMS_RESET = CFG_W'(MAX_TERMS);
  localparam logic [RES_W-1:0] OUT_POS_MAX = RES_W'(24'h7FFFFF);
  localparam logic [RES_W-1:0] OUT_NEG_MAX = RES_W'(25'h0800000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQ_LOAD,
    ST_RUN,
    ST_DONE
  } ssu_state_e;

  typedef enum logic [2:0] {
    PH_T_LO,
    PH_T_HI,
    PH_T_ACC,
    PH_M_LO,
    PH_M_HI,
    PH_M_ACC,
    PH_SUM
  } ssu_phase_e;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag;
    logic [CFG_W-1:0] terms;
  } ssu_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ssu_stat_t;

  // Q32 reciprocal of (2k+2)(2k+3), rounded to nearest.
  function automatic logic [RECIP_W-1:0] recip_f(input logic [K_W-1:0] k);
    logic [RECIP_W-1:0] r;
    case (k)
      4'd0:    r = RECIP_W'(715827883);
      4'd1:    r = RECIP_W'(214748365);
      4'd2:    r = RECIP_W'(102261126);
      4'd3:    r = RECIP_W'(59652324);
      4'd4:    r = RECIP_W'(39045157);
      4'd5:    r = RECIP_W'(27531842);
      4'd6:    r = RECIP_W'(20452225);
      4'd7:    r = RECIP_W'(15790321);
      4'd8:    r = RECIP_W'(12558384);
      4'd9:    r = RECIP_W'(10226113);
      4'd10:   r = RECIP_W'(8488078);
      4'd11:   r = RECIP_W'(7158279);
      4'd12:   r = RECIP_W'(6118187);
      4'd13:   r = RECIP_W'(5289369);
      4'd14:   r = RECIP_W'(4618244);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ssu_mult.sv */
// Shared unsigned multiplier with registered product.
// Depends on ssu_pkg for operand widths.
`default_nettype none

module ssu_mult (
  input  wire logic                        clk_i,
  input  wire logic [ssu_pkg::MUL_A_W-1:0] a_i,
  input  wire logic [ssu_pkg::MUL_B_W-1:0] b_i,
  output logic      [ssu_pkg::MUL_P_W-1:0] p_o
);

  logic [ssu_pkg::MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ssu_pkg::MUL_P_W'(a_i) * ssu_pkg::MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* rtl/ssu_core.sv */
// Series sequencer: squares |x|, then forms each term from the last with
// two split multiplies on ssu_mult and accumulates the sum. Uses ssu_pkg.
`default_nettype none

module ssu_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ssu_pkg::ssu_cmd_t         cmd_i,
  input  wire logic                      take_i,
  output ssu_pkg::ssu_stat_t             stat_o,
  output logic      [ssu_pkg::SUM_W-1:0] sum_o
);

  ssu_pkg::ssu_state_e state_q, state_d;
  ssu_pkg::ssu_phase_e phase_q, phase_d;

  logic [ssu_pkg::K_W-1:0]    k_q, k_d;
  logic [ssu_pkg::K_W-1:0]    last_q, last_d;
  logic                       multi_q, multi_d;
  logic [ssu_pkg::TERM_W-1:0] term_q, term_d;
  logic [ssu_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [ssu_pkg::X2_W-1:0]   x2_q, x2_d;
  logic [ssu_pkg::MID_W-1:0]  mid_q, mid_d;
  logic [ssu_pkg::ACC_W-1:0]  acc_q, acc_d;

  logic [ssu_pkg::MUL_A_W-1:0] mul_a;
  logic [ssu_pkg::MUL_B_W-1:0] mul_b;
  logic [ssu_pkg::MUL_P_W-1:0] mul_p;
  logic [ssu_pkg::MID_W-1:0]   mid_w;
  logic [ssu_pkg::TERM_W-1:0]  term_w;
  logic [ssu_pkg::MUL_B_W-1:0] recip_w;

  ssu_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign mid_w   = acc_q[2*ssu_pkg::FRAC_BITS +: ssu_pkg::MID_W];
  assign term_w  = acc_q[ssu_pkg::RECIP_BITS +: ssu_pkg::TERM_W];
  assign recip_w = ssu_pkg::MUL_B_W'(ssu_pkg::recip_f(k_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssu_pkg::ST_IDLE;
      phase_q <= ssu_pkg::PH_T_LO;
      k_q     <= '0;
      last_q  <= '0;
      multi_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      k_q     <= k_d;
      last_q  <= last_d;
      multi_q <= multi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    sum_q  <= sum_d;
    x2_q   <= x2_d;
    mid_q  <= mid_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    k_d     = k_q;
    last_d  = last_q;
    multi_d = multi_q;
    term_d  = term_q;
    sum_d   = sum_q;
    x2_d    = x2_q;
    mid_d   = mid_q;
    acc_d   = acc_q;
    mul_a   = '0;
    mul_b   = '0;

    case (state_q)
      ssu_pkg::ST_IDLE: begin
        if (cmd_i.start) begin
          term_d  = ssu_pkg::TERM_W'(cmd_i.mag) << ssu_pkg::GUARD_BITS;
          sum_d   = ssu_pkg::SUM_W'(cmd_i.mag) << ssu_pkg::GUARD_BITS;
          multi_d = (cmd_i.terms != ssu_pkg::CFG_W'(1));
          last_d  = ssu_pkg::K_W'(cmd_i.terms - ssu_pkg::CFG_W'(2));
          state_d = ssu_pkg::ST_SQUARE;
        end
      end
      ssu_pkg::ST_SQUARE: begin
        mul_a   = ssu_pkg::MUL_A_W'(term_q[ssu_pkg::GUARD_BITS +: ssu_pkg::MAG_W]);
        mul_b   = ssu_pkg::MUL_B_W'(term_q[ssu_pkg::GUARD_BITS +: ssu_pkg::MAG_W]);
        state_d = ssu_pkg::ST_SQ_LOAD;
      end
      ssu_pkg::ST_SQ_LOAD: begin
        x2_d    = mul_p[ssu_pkg::X2_W-1:0];
        k_d     = '0;
        phase_d = ssu_pkg::PH_T_LO;
        state_d = multi_q ? ssu_pkg::ST_RUN : ssu_pkg::ST_DONE;
      end
      ssu_pkg::ST_RUN: begin
        case (phase_q)
          ssu_pkg::PH_T_LO: begin
            mul_a   = ssu_pkg::MUL_A_W'(term_q[ssu_pkg::TERM_HALF-1:0]);
            mul_b   = x2_q;
            acc_d   = '0;
            phase_d = ssu_pkg::PH_T_HI;
          end
          ssu_pkg::PH_T_HI: begin
            mul_a   = ssu_pkg::MUL_A_W'(term_q[ssu_pkg::TERM_W-1:ssu_pkg::TERM_HALF]);
            mul_b   = x2_q;
            acc_d   = ssu_pkg::ACC_W'(mul_p);
            phase_d = ssu_pkg::PH_T_ACC;
          end
          ssu_pkg::PH_T_ACC: begin
            acc_d   = acc_q + (ssu_pkg::ACC_W'(mul_p) << ssu_pkg::TERM_HALF);
            phase_d = ssu_pkg::PH_M_LO;
          end
          ssu_pkg::PH_M_LO: begin
            mul_a   = mid_w[ssu_pkg::MID_HALF-1:0];
            mul_b   = recip_w;
            mid_d   = mid_w;
            phase_d = ssu_pkg::PH_M_HI;
          end
          ssu_pkg::PH_M_HI: begin
            mul_a   = mid_q[ssu_pkg::MID_W-1:ssu_pkg::MID_HALF];
            mul_b   = recip_w;
            acc_d   = ssu_pkg::ACC_W'(mul_p);
            phase_d = ssu_pkg::PH_M_ACC;
          end
          ssu_pkg::PH_M_ACC: begin
            acc_d   = acc_q + (ssu_pkg::ACC_W'(mul_p) << ssu_pkg::MID_HALF);
            phase_d = ssu_pkg::PH_SUM;
          end
          ssu_pkg::PH_SUM: begin
            term_d  = term_w;
            sum_d   = sum_q + term_w;
            phase_d = ssu_pkg::PH_T_LO;
            if (k_q == last_q) begin
              state_d = ssu_pkg::ST_DONE;
            end else begin
              k_d = k_q + ssu_pkg::K_W'(1);
            end
          end
          default: begin
            phase_d = ssu_pkg::PH_T_LO;
          end
        endcase
      end
      ssu_pkg::ST_DONE: begin
        if (take_i) begin
          state_d = ssu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssu_pkg::ST_IDLE;
      end
    endcase
  end

  assign stat_o.idle = (state_q == ssu_pkg::ST_IDLE);
  assign stat_o.done = (state_q == ssu_pkg::ST_DONE);
  assign sum_o       = sum_q;

`ifndef NO_ASSERTIONS
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssu_pkg::ST_RUN |-> k_q <= last_q)
    else $error("term index past last term");

  a_sum_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssu_pkg::ST_RUN |=> sum_q >= $past(sum_q))
    else $error("series sum decreased");
`endif

endmodule

`default_nettype wire

/* rtl/sinh_series_unit.sv */
// sinh(x) by odd Taylor series: x in Q4.12 in, Q12.12 out, saturated.
// Top level with handshakes, terms register and output stage; uses ssu_core.
//
// One beat at a time: after an x beat is accepted, ready stays low while
// the series runs on a single shared 22x31 multiplier. |x| is squared
// first, each term after the first takes two split multiplies and the add
// into the sum, and the rounded result then moves to the output register.
// A new x is taken as soon as the result leaves the core, even while the
// previous result still waits on the output. The terms register (0 acts
// as 1, above 16 acts as 16) is always ready and resets to 16.
`default_nettype none

module sinh_series_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic        [ssu_pkg::CFG_W-1:0] terms_in_use_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [ssu_pkg::X_W-1:0]   x_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed      [ssu_pkg::OUT_W-1:0] sinh_value_o
);

  logic [ssu_pkg::CFG_W-1:0] terms_q;
  logic [ssu_pkg::CFG_W-1:0] terms_eff;
  logic                      neg_q;
  logic                      out_valid_q;
  logic [ssu_pkg::OUT_W-1:0] sinh_q, sinh_d;

  ssu_pkg::ssu_cmd_t  cmd;
  ssu_pkg::ssu_stat_t stat;

  logic [ssu_pkg::SUM_W-1:0] sum;
  logic [ssu_pkg::X_W-1:0]   x_u;
  logic [ssu_pkg::SUM_W:0]   round_w;
  logic [ssu_pkg::RES_W-1:0] res_w;
  logic [ssu_pkg::RES_W-1:0] res_sat;
  logic                      accept_w;
  logic                      load_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      terms_q <= ssu_pkg::TERMS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      terms_q <= terms_in_use_i;
    end
  end

  always_comb begin
    if (terms_q == '0) begin
      terms_eff = ssu_pkg::CFG_W'(1);
    end else if (terms_q > ssu_pkg::CFG_W'(ssu_pkg::MAX_TERMS)) begin
      terms_eff = ssu_pkg::CFG_W'(ssu_pkg::MAX_TERMS);
    end else begin
      terms_eff = terms_q;
    end
  end

  assign x_u        = unsigned'(x_value_i);
  assign in_ready_o = stat.idle;
  assign accept_w   = in_valid_i && in_ready_o;

  assign cmd.start = accept_w;
  assign cmd.mag   = x_u[ssu_pkg::X_W-1] ? (~x_u + ssu_pkg::X_W'(1)) : x_u;
  assign cmd.terms = terms_eff;

  ssu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .take_i (load_w),
    .stat_o (stat),
    .sum_o  (sum)
  );

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      neg_q <= x_u[ssu_pkg::X_W-1];
    end
  end

  // round half up, saturate, restore sign
  always_comb begin
    round_w = {1'b0, sum} + ((ssu_pkg::SUM_W + 1)'(1) << (ssu_pkg::GUARD_BITS - 1));
    res_w   = round_w[ssu_pkg::SUM_W:ssu_pkg::GUARD_BITS];
    if (neg_q) begin
      res_sat = (res_w > ssu_pkg::OUT_NEG_MAX) ? ssu_pkg::OUT_NEG_MAX : res_w;
      sinh_d  = ssu_pkg::OUT_W'(~res_sat + ssu_pkg::RES_W'(1));
    end else begin
      res_sat = (res_w > ssu_pkg::OUT_POS_MAX) ? ssu_pkg::OUT_POS_MAX : res_w;
      sinh_d  = ssu_pkg::OUT_W'(res_sat);
    end
  end

  assign load_w = stat.done && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_w) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_w) begin
      sinh_q <= sinh_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sinh_value_o = signed'(sinh_q);

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new x taken while series still running");

  a_sign_follows_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_w |=> !sinh_q[ssu_pkg::OUT_W-1] || $past(neg_q))
    else $error("negative result for non-negative x");
`endif

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Testbench for sinh_series_unit: directed table, then random x in phases with
// different term counts and idle patterns, checked against a bit-true predictor.
// Depends on rtl/ssu_pkg.sv and rtl/sinh_series_unit.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 12;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          DRAIN_CYCLES = 150;
  localparam int          PHASE_ITEMS  = 150;
  localparam int          NUM_PHASES   = 8;
  localparam logic [63:0] INNER_CAP    = (64'd1 << 60) - 64'd1;

  typedef struct packed {
    logic [ssu_pkg::CFG_W-1:0]        terms;
    logic signed [ssu_pkg::X_W-1:0]   x;
    logic                             known;
    logic signed [ssu_pkg::OUT_W-1:0] sinh;
  } drow_t;

  localparam int NUM_ROWS = 21;
  localparam drow_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{5'd16, 16'sd0,      1'b1, 24'sd0},
    '{5'd16, 16'sh7FFF,   1'b0, 24'sd0},
    '{5'd16, 16'sh8000,   1'b0, 24'sd0},
    '{5'd16, 16'sd1,      1'b0, 24'sd0},
    '{5'd16, -16'sd1,     1'b0, 24'sd0},
    '{5'd16, 16'sd4096,   1'b0, 24'sd0},
    '{5'd16, -16'sd4096,  1'b0, 24'sd0},
    '{5'd1,  16'sh7FFF,   1'b1, 24'sd32767},
    '{5'd1,  16'sh8000,   1'b1, -24'sd32768},
    '{5'd1,  16'sd1,      1'b1, 24'sd1},
    '{5'd1,  -16'sd1,     1'b1, -24'sd1},
    '{5'd1,  16'sd0,      1'b1, 24'sd0},
    '{5'd0,  16'sd12345,  1'b1, 24'sd12345},
    '{5'd0,  -16'sd20000, 1'b1, -24'sd20000},
    '{5'd31, 16'sh7FFF,   1'b0, 24'sd0},
    '{5'd31, 16'sh8000,   1'b0, 24'sd0},
    '{5'd31, 16'sd0,      1'b1, 24'sd0},
    '{5'd17, 16'sh8000,   1'b0, 24'sd0},
    '{5'd2,  16'sd4096,   1'b0, 24'sd0},
    '{5'd2,  -16'sd12288, 1'b0, 24'sd0},
    '{5'd16, 16'sd20480,  1'b0, 24'sd0}
  };

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [ssu_pkg::CFG_W-1:0]        terms_in_use_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic signed [ssu_pkg::X_W-1:0]   x_value_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic signed [ssu_pkg::OUT_W-1:0] sinh_value_o;

  logic                             beat_known;
  logic signed [ssu_pkg::OUT_W-1:0] beat_sinh;
  logic [ssu_pkg::CFG_W-1:0]        cfg_terms;
  logic [ssu_pkg::CFG_W-1:0]        drv_terms;
  int                               send_idle_pct;
  int                               recv_stall_pct;
  int                               mismatch_count = 0;
  int                               quiet_cycles = 0;
  logic signed [ssu_pkg::OUT_W-1:0] sinh_expected [$];

  sinh_series_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .terms_in_use_i (terms_in_use_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .x_value_i      (x_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sinh_value_o   (sinh_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // floor(a*b / 2^s), saturated at the inner cap
  function automatic logic [63:0] product_shift_sat(input logic [63:0] a,
                                                    input logic [63:0] b,
                                                    input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return (p > {64'd0, INNER_CAP}) ? INNER_CAP : p[63:0];
  endfunction

  function automatic logic signed [ssu_pkg::OUT_W-1:0] sinh_fixed(
      input logic signed [ssu_pkg::X_W-1:0] x,
      input logic [ssu_pkg::CFG_W-1:0]      terms);
    logic        neg;
    logic [63:0] mag, x2, term, sum, d, recip, res;
    int          n, k;
    neg  = x[ssu_pkg::X_W-1];
    mag  = neg ? (64'h10000 - {48'd0, x}) : {48'd0, x};
    x2   = mag * mag;
    term = mag << ssu_pkg::GUARD_BITS;
    sum  = term;
    n    = (terms == 0) ? 1 :
           ((terms > ssu_pkg::MAX_TERMS) ? ssu_pkg::MAX_TERMS : int'(terms));
    for (k = 0; k + 1 < n; k++) begin
      d     = 64'((2 * k + 2) * (2 * k + 3));
      recip = ((64'd1 << ssu_pkg::RECIP_BITS) + d / 2) / d;
      term  = product_shift_sat(term, x2, 2 * ssu_pkg::FRAC_BITS);
      term  = product_shift_sat(term, recip, ssu_pkg::RECIP_BITS);
      sum   = (sum > INNER_CAP - term) ? INNER_CAP : sum + term;
    end
    res = (sum + (64'd1 << (ssu_pkg::GUARD_BITS - 1))) >> ssu_pkg::GUARD_BITS;
    if (neg) begin
      if (res > 64'd8388608) res = 64'd8388608;
      return ssu_pkg::OUT_W'(64'd0 - res);
    end else begin
      if (res > 64'd8388607) res = 64'd8388607;
      return ssu_pkg::OUT_W'(res);
    end
  endfunction

  // Beat monitor: predicts on input beats, checks on output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_terms <= ssu_pkg::TERMS_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cfg_terms <= terms_in_use_i;
      if (in_valid_i && in_ready_o)
        sinh_expected.push_back(beat_known ? beat_sinh : sinh_fixed(x_value_i, cfg_terms));
      if (out_valid_o && out_ready_i) begin
        if (sinh_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, sinh_value_o);
          mismatch_count++;
        end else if (sinh_value_o !== sinh_expected[0]) begin
          $display("%0t: sinh mismatch, expected %0d, actual %0d",
                   $time, sinh_expected[0], sinh_value_o);
          mismatch_count++;
          void'(sinh_expected.pop_front());
        end else begin
          void'(sinh_expected.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_terms(input logic [ssu_pkg::CFG_W-1:0] terms);
    while (sinh_expected.size() != 0) @(negedge clk_i);
    cfg_valid_i    = 1'b1;
    terms_in_use_i = terms;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    drv_terms   = terms;
  endtask

  // Starts and ends on a falling edge; valid stays high into the next beat.
  task automatic send_x(input logic signed [ssu_pkg::X_W-1:0] x, input logic known,
                        input logic signed [ssu_pkg::OUT_W-1:0] sinh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    x_value_i  = x;
    beat_known = known;
    beat_sinh  = sinh;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic signed [ssu_pkg::X_W-1:0] random_x();
    logic signed [ssu_pkg::X_W-1:0] v;
    case ($urandom_range(3))
      0: v = ssu_pkg::X_W'($urandom_range(4096));
      1: v = ssu_pkg::X_W'($urandom_range(32767, 32767 - 511));
      default: v = ssu_pkg::X_W'($urandom);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  initial begin
    logic [ssu_pkg::CFG_W-1:0] phase_terms;
    int                        p, i;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    terms_in_use_i = '0;
    in_valid_i     = 1'b0;
    x_value_i      = '0;
    beat_known     = 1'b0;
    beat_sinh      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drv_terms      = ssu_pkg::TERMS_RESET;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED_ROWS[i].terms != drv_terms) begin
        in_valid_i = 1'b0;
        write_terms(DIRECTED_ROWS[i].terms);
      end
      send_x(DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].sinh);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_terms = 5'd16;
        1: phase_terms = 5'd1;
        2: phase_terms = 5'd0;
        3: phase_terms = 5'd31;
        4: phase_terms = ssu_pkg::CFG_W'($urandom_range(15, 2));
        6: phase_terms = 5'd17;
        default: phase_terms = ssu_pkg::CFG_W'($urandom_range(31));
      endcase
      in_valid_i = 1'b0;
      write_terms(phase_terms);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) send_x(random_x(), 1'b0, '0);
    end

    in_valid_i = 1'b0;
    while (sinh_expected.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && sinh_expected.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* sinh_series_unit.f */
rtl/ssu_pkg.sv
rtl/ssu_mult.sv
rtl/ssu_core.sv
rtl/sinh_series_unit.sv
verif/testbench.sv
